FILE: src/lav_pkg.sv
// Shared constants for the look-at view matrix block.
package lav_pkg;

  // Default word and fraction widths of the fixed-point fields.
  localparam int WordBitsDef = 32;
  localparam int FracBitsDef = 16;

  // Direction magnitudes are scaled so the largest has its top bit here.
  localparam int NormTop = 29;
  localparam int NormW   = NormTop + 1;
  // Sum of three squared scaled magnitudes.
  localparam int LenW    = 2 * NormW + 2;

endpackage

FILE: src/lav_req_if.sv
// Request channel: up vector, target point and eye position.
interface lav_req_if import lav_pkg::*; #(
  parameter int WordBits = WordBitsDef
) ();
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] up_x;
  logic signed [WordBits-1:0] up_y;
  logic signed [WordBits-1:0] up_z;
  logic signed [WordBits-1:0] target_x;
  logic signed [WordBits-1:0] target_y;
  logic signed [WordBits-1:0] target_z;
  logic signed [WordBits-1:0] eye_x;
  logic signed [WordBits-1:0] eye_y;
  logic signed [WordBits-1:0] eye_z;

  modport source (
    output valid, up_x, up_y, up_z, target_x, target_y, target_z, eye_x, eye_y, eye_z,
    input  ready
  );
  modport sink (
    input  valid, up_x, up_y, up_z, target_x, target_y, target_z, eye_x, eye_y, eye_z,
    output ready
  );
endinterface

FILE: src/lav_rsp_if.sv
// Result channel: view matrix basis and translation terms.
interface lav_rsp_if import lav_pkg::*; #(
  parameter int WordBits = WordBitsDef
) ();
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] side_x;
  logic signed [WordBits-1:0] side_y;
  logic signed [WordBits-1:0] side_z;
  logic signed [WordBits-1:0] true_up_x;
  logic signed [WordBits-1:0] true_up_y;
  logic signed [WordBits-1:0] true_up_z;
  logic signed [WordBits-1:0] back_x;
  logic signed [WordBits-1:0] back_y;
  logic signed [WordBits-1:0] back_z;
  logic signed [WordBits-1:0] shift_side;
  logic signed [WordBits-1:0] shift_up;
  logic signed [WordBits-1:0] shift_back;

  modport source (
    output valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_side, shift_up, shift_back,
    input  ready
  );
  modport sink (
    input  valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_side, shift_up, shift_back,
    output ready
  );
endinterface

FILE: src/lav_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module lav_isqrt import lav_pkg::*; #(
  parameter int InW   = LenW,
  parameter int SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [InW-1:0]     rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               vld_o,
  output logic [InW/2-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);
  localparam int Steps = InW / 2;

  logic [InW-1:0]   rem_q  [Steps];
  logic [InW-1:0]   res_q  [Steps];
  logic [SideW-1:0] side_q [Steps];
  logic             vld_q  [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [InW-1:0]   rem_c, res_c, rem_n, res_n;
    logic [SideW-1:0] side_c;
    logic             vld_c;

    if (j == 0) begin : g_first
      assign rem_c  = rad_i;
      assign res_c  = '0;
      assign side_c = side_i;
      assign vld_c  = vld_i;
    end else begin : g_next
      assign rem_c  = rem_q[j-1];
      assign res_c  = res_q[j-1];
      assign side_c = side_q[j-1];
      assign vld_c  = vld_q[j-1];
    end

    // Try one more root bit; keep it when the remainder allows.
    always_comb begin : p_try
      logic [InW-1:0] bit_w, trial;
      bit_w = InW'(1) << (InW - 2 - 2 * j);
      trial = res_c + bit_w;
      if (rem_c >= trial) begin
        rem_n = rem_c - trial;
        res_n = (res_c >> 1) + bit_w;
      end else begin
        rem_n = rem_c;
        res_n = res_c >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_n;
        res_q[j]  <= res_n;
        side_q[j] <= side_c;
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign root_o = res_q[Steps-1][Steps-1:0];
  assign side_o = side_q[Steps-1];

endmodule

FILE: src/lav_div.sv
// Pipelined restoring divider, several numerators over one divisor.
module lav_div import lav_pkg::*; #(
  parameter int DenW  = LenW / 2,
  parameter int QuoW  = FracBitsDef + 1,
  parameter int Lanes = 3,
  parameter int SideW = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [DenW-1:0]                    den_i,
  input  logic [Lanes-1:0][DenW+QuoW-1:0]    num_i,
  input  logic [SideW-1:0]                   side_i,
  output logic                               vld_o,
  output logic [Lanes-1:0][QuoW-1:0]         quo_o,
  output logic [SideW-1:0]                   side_o
);
  localparam int NumW = DenW + QuoW;
  localparam int AccW = NumW + 1;

  logic [Lanes-1:0][AccW-1:0] acc_q  [QuoW];
  logic [DenW-1:0]            den_q  [QuoW];
  logic [SideW-1:0]           side_q [QuoW];
  logic                       vld_q  [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_step
    logic [Lanes-1:0][AccW-1:0] acc_c, acc_n;
    logic [DenW-1:0]            den_c;
    logic [SideW-1:0]           side_c;
    logic                       vld_c;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < Lanes; l++) begin : g_ld
        assign acc_c[l] = {1'b0, num_i[l]};
      end
      assign den_c  = den_i;
      assign side_c = side_i;
      assign vld_c  = vld_i;
    end else begin : g_next
      assign acc_c  = acc_q[j-1];
      assign den_c  = den_q[j-1];
      assign side_c = side_q[j-1];
      assign vld_c  = vld_q[j-1];
    end

    // Shift in the next numerator bit, subtract when it fits.
    always_comb begin : p_sub
      logic [AccW-1:0] sh;
      for (int l = 0; l < Lanes; l++) begin
        sh = {acc_c[l][AccW-2:0], 1'b0};
        if (sh[AccW-1:QuoW] >= {1'b0, den_c}) begin
          acc_n[l] = {sh[AccW-1:QuoW] - {1'b0, den_c}, sh[QuoW-1:1], 1'b1};
        end else begin
          acc_n[l] = sh;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j]  <= acc_n;
        den_q[j]  <= den_c;
        side_q[j] <= side_c;
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign quo_o[l] = acc_q[QuoW-1][l][QuoW-1:0];
  end
  assign vld_o  = vld_q[QuoW-1];
  assign side_o = side_q[QuoW-1];

endmodule

FILE: src/look_at_view_matrix.sv
// Right-handed look-at view matrix in signed fixed point, fully pipelined.
//
//   channel  dir  fields                                    meaning
//   src_i    in   up_*, target_*, eye_*                     one camera request
//   dst_o    out  side_*, true_up_*, back_*, shift_*        basis and translation
//
// One request enters per cycle unless the pipe is stalled. The pipe has five prep
// stages, one square-root stage per root bit (31), one numerator stage, one divider
// stage per quotient bit, and seven matrix stages.
// All stages advance together: a result waiting in the output register with no
// ready stalls the whole pipe, and src_i.ready drops in that same cycle.
// Reset clears only the valid bits; payload registers come up unknown.
module look_at_view_matrix import lav_pkg::*; #(
  parameter int WORD_BITS     = WordBitsDef,
  parameter int FRACTION_BITS = FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lav_req_if.sink       src_i,
  lav_rsp_if.source     dst_o
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int DW   = W + 1;              // eye minus target
  localparam int TW   = $clog2(DW);         // msb index of a magnitude
  localparam int SQW  = 2 * NormW;          // one scaled square
  localparam int RW   = LenW / 2;           // root of the length squared
  localparam int QW   = F + 1;              // back magnitude, at most 2^F
  localparam int NW   = RW + QW;            // divider numerator
  localparam int BW   = F + 2;              // signed back component
  localparam int PW   = W + BW;             // word times back component
  localparam int EW   = 2 * W;              // word times word
  localparam int SUMW = ((EW > PW) ? EW : PW) + 3;
  localparam int CtxW = 3 + 6 * W;          // signs, up, eye
  localparam int SideA = 3 * NormW + 1 + CtxW;
  localparam int SideB = 1 + CtxW;

  localparam logic signed [SUMW-1:0] Half = SUMW'(1) <<< (F - 1);
  localparam logic signed [SUMW-1:0] WMax = (SUMW'(1) <<< (W - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] WMin = -(SUMW'(1) <<< (W - 1));
  localparam logic signed [BW-1:0]   One  = BW'(1) <<< F;

  // Clamp to the signed word range.
  function automatic logic signed [W-1:0] sat_w(input logic signed [SUMW-1:0] v);
    if (v > WMax) return W'(WMax);
    if (v < WMin) return W'(WMin);
    return W'(v);
  endfunction

  // Drop the fraction rounding half up, then clamp.
  function automatic logic signed [W-1:0] round_sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] t;
    t = (v + Half) >>> F;
    return sat_w(t);
  endfunction

  // Global advance: move everything unless the output register is held.
  logic en;
  logic s13_vld_q;
  assign en          = !s13_vld_q || dst_o.ready;
  assign src_i.ready = en;

  //--------------------------------------------------------------------------
  // Stage 1: eye minus target, split into sign and magnitude.
  logic signed [W-1:0]  in_up [3], in_tg [3], in_eye [3];
  logic signed [DW-1:0] d1 [3];
  logic [DW-1:0]        m1 [3];

  assign in_up[0]  = src_i.up_x;
  assign in_up[1]  = src_i.up_y;
  assign in_up[2]  = src_i.up_z;
  assign in_tg[0]  = src_i.target_x;
  assign in_tg[1]  = src_i.target_y;
  assign in_tg[2]  = src_i.target_z;
  assign in_eye[0] = src_i.eye_x;
  assign in_eye[1] = src_i.eye_y;
  assign in_eye[2] = src_i.eye_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = DW'(in_eye[i]) - DW'(in_tg[i]);
      m1[i] = d1[i][DW-1] ? DW'(-d1[i]) : DW'(d1[i]);
    end
  end

  logic            s1_vld_q;
  logic [DW-1:0]   s1_mag_q [3];
  logic [CtxW-1:0] s1_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s1_mag_q[i] <= m1[i];
      s1_ctx_q <= {d1[0][DW-1], d1[1][DW-1], d1[2][DW-1],
                   in_up[0], in_up[1], in_up[2], in_eye[0], in_eye[1], in_eye[2]};
    end
  end

  //--------------------------------------------------------------------------
  // Stage 2: msb position of the largest magnitude (msb of the OR).
  logic [DW-1:0] mor2;
  logic [TW-1:0] top2;

  assign mor2 = s1_mag_q[0] | s1_mag_q[1] | s1_mag_q[2];

  always_comb begin
    top2 = '0;
    for (int b = 0; b < DW; b++) begin
      if (mor2[b]) top2 = TW'(b);
    end
  end

  logic            s2_vld_q, s2_zero_q;
  logic [TW-1:0]   s2_top_q;
  logic [DW-1:0]   s2_mag_q [3];
  logic [CtxW-1:0] s2_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_zero_q <= ~|mor2;
      s2_top_q  <= top2;
      s2_mag_q  <= s1_mag_q;
      s2_ctx_q  <= s1_ctx_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 3: scale all three by one power of two, top bit to NormTop.
  logic [DW+NormTop-1:0] wide3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide3[i] = {s2_mag_q[i], NormTop'(0)} >> s2_top_q;
    end
  end

  logic             s3_vld_q, s3_zero_q;
  logic [NormW-1:0] s3_sc_q [3];
  logic [NormW-1:0] s3_sc_or;
  logic [CtxW-1:0]  s3_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_sc_q[i] <= wide3[i][NormW-1:0];
      s3_zero_q <= s2_zero_q;
      s3_ctx_q  <= s2_ctx_q;
    end
  end

  assign s3_sc_or = s3_sc_q[0] | s3_sc_q[1] | s3_sc_q[2];

  //--------------------------------------------------------------------------
  // Stage 4: squares.  Stage 5: length squared.
  logic             s4_vld_q, s4_zero_q;
  logic [SQW-1:0]   s4_sq_q [3];
  logic [NormW-1:0] s4_sc_q [3];
  logic [CtxW-1:0]  s4_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_sq_q[i] <= SQW'(s3_sc_q[i]) * SQW'(s3_sc_q[i]);
      s4_sc_q   <= s3_sc_q;
      s4_zero_q <= s3_zero_q;
      s4_ctx_q  <= s3_ctx_q;
    end
  end

  logic             s5_vld_q, s5_zero_q;
  logic [LenW-1:0]  s5_len_q;
  logic [NormW-1:0] s5_sc_q [3];
  logic [CtxW-1:0]  s5_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_len_q  <= LenW'(s4_sq_q[0]) + LenW'(s4_sq_q[1]) + LenW'(s4_sq_q[2]);
      s5_sc_q   <= s4_sc_q;
      s5_zero_q <= s4_zero_q;
      s5_ctx_q  <= s4_ctx_q;
    end
  end

  //--------------------------------------------------------------------------
  // Square root of the length squared, scaled magnitudes ride along.
  logic             sq_vld;
  logic [RW-1:0]    sq_root;
  logic [SideA-1:0] sq_side;
  logic [NormW-1:0] a_sc [3];
  logic             a_zero;
  logic [CtxW-1:0]  a_ctx;

  lav_isqrt #(
    .InW   (LenW),
    .SideW (SideA)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .rad_i  (s5_len_q),
    .side_i ({s5_sc_q[0], s5_sc_q[1], s5_sc_q[2], s5_zero_q, s5_ctx_q}),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign {a_sc[0], a_sc[1], a_sc[2], a_zero, a_ctx} = sq_side;

  //--------------------------------------------------------------------------
  // Stage 6: numerators with half the divisor added for rounding.
  logic                     s6_vld_q;
  logic [RW-1:0]            s6_r_q;
  logic [2:0][NW-1:0]       s6_num_q;
  logic [SideB-1:0]         s6_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_num_q[i] <= (NW'(a_sc[i]) << F) + NW'(sq_root >> 1);
      end
      s6_r_q    <= sq_root;
      s6_side_q <= {a_zero, a_ctx};
    end
  end

  //--------------------------------------------------------------------------
  // Divide each numerator by the root.
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_quo;
  logic [SideB-1:0]   dv_side;
  logic               b_zero;
  logic [2:0]         b_sgn;
  logic signed [W-1:0] b_up [3], b_eye [3];

  lav_div #(
    .DenW  (RW),
    .QuoW  (QW),
    .Lanes (3),
    .SideW (SideB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .den_i  (s6_r_q),
    .num_i  (s6_num_q),
    .side_i (s6_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  assign {b_zero, b_sgn, b_up[0], b_up[1], b_up[2], b_eye[0], b_eye[1], b_eye[2]} = dv_side;

  //--------------------------------------------------------------------------
  // Stage 7: signed back vector; zero length gives zero.
  logic                 s7_vld_q;
  logic signed [BW-1:0] s7_bk_q  [3];
  logic signed [W-1:0]  s7_up_q  [3];
  logic signed [W-1:0]  s7_eye_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (b_zero) begin
          s7_bk_q[i] <= '0;
        end else if (b_sgn[2-i]) begin
          s7_bk_q[i] <= -$signed({1'b0, dv_quo[i]});
        end else begin
          s7_bk_q[i] <= $signed({1'b0, dv_quo[i]});
        end
      end
      s7_up_q  <= b_up;
      s7_eye_q <= b_eye;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 8: up cross back, products.
  logic                 s8_vld_q;
  logic signed [PW-1:0] s8_p_q   [6];
  logic signed [BW-1:0] s8_bk_q  [3];
  logic signed [W-1:0]  s8_eye_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_p_q[0] <= PW'(s7_up_q[1]) * PW'(s7_bk_q[2]);
      s8_p_q[1] <= PW'(s7_up_q[2]) * PW'(s7_bk_q[1]);
      s8_p_q[2] <= PW'(s7_up_q[2]) * PW'(s7_bk_q[0]);
      s8_p_q[3] <= PW'(s7_up_q[0]) * PW'(s7_bk_q[2]);
      s8_p_q[4] <= PW'(s7_up_q[0]) * PW'(s7_bk_q[1]);
      s8_p_q[5] <= PW'(s7_up_q[1]) * PW'(s7_bk_q[0]);
      s8_bk_q   <= s7_bk_q;
      s8_eye_q  <= s7_eye_q;
    end
  end

  // Stage 9: side vector; clamp back for output.
  logic                 s9_vld_q;
  logic signed [W-1:0]  s9_sd_q  [3];
  logic signed [W-1:0]  s9_bo_q  [3];
  logic signed [BW-1:0] s9_bk_q  [3];
  logic signed [W-1:0]  s9_eye_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s9_sd_q[i] <= round_sat(SUMW'(s8_p_q[2*i]) - SUMW'(s8_p_q[2*i+1]));
        s9_bo_q[i] <= sat_w(SUMW'(s8_bk_q[i]));
      end
      s9_bk_q  <= s8_bk_q;
      s9_eye_q <= s8_eye_q;
    end
  end

  // Stage 10: back cross side, eye dot side, eye dot back products.
  logic                 s10_vld_q;
  logic signed [PW-1:0] s10_t_q  [6];
  logic signed [EW-1:0] s10_es_q [3];
  logic signed [PW-1:0] s10_eb_q [3];
  logic signed [W-1:0]  s10_sd_q [3];
  logic signed [W-1:0]  s10_bo_q [3];
  logic signed [W-1:0]  s10_eye_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_t_q[0] <= PW'(s9_bk_q[1]) * PW'(s9_sd_q[2]);
      s10_t_q[1] <= PW'(s9_bk_q[2]) * PW'(s9_sd_q[1]);
      s10_t_q[2] <= PW'(s9_bk_q[2]) * PW'(s9_sd_q[0]);
      s10_t_q[3] <= PW'(s9_bk_q[0]) * PW'(s9_sd_q[2]);
      s10_t_q[4] <= PW'(s9_bk_q[0]) * PW'(s9_sd_q[1]);
      s10_t_q[5] <= PW'(s9_bk_q[1]) * PW'(s9_sd_q[0]);
      for (int i = 0; i < 3; i++) begin
        s10_es_q[i] <= EW'(s9_eye_q[i]) * EW'(s9_sd_q[i]);
        s10_eb_q[i] <= PW'(s9_eye_q[i]) * PW'(s9_bk_q[i]);
      end
      s10_sd_q  <= s9_sd_q;
      s10_bo_q  <= s9_bo_q;
      s10_eye_q <= s9_eye_q;
    end
  end

  // Stage 11: true up, side and back translation terms.
  logic                s11_vld_q;
  logic signed [W-1:0] s11_tu_q [3];
  logic signed [W-1:0] s11_sd_q [3];
  logic signed [W-1:0] s11_bo_q [3];
  logic signed [W-1:0] s11_eye_q [3];
  logic signed [W-1:0] s11_ss_q, s11_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s11_tu_q[i] <= round_sat(SUMW'(s10_t_q[2*i]) - SUMW'(s10_t_q[2*i+1]));
      end
      s11_ss_q  <= round_sat(-(SUMW'(s10_es_q[0]) + SUMW'(s10_es_q[1])
                               + SUMW'(s10_es_q[2])));
      s11_sb_q  <= round_sat(-(SUMW'(s10_eb_q[0]) + SUMW'(s10_eb_q[1])
                               + SUMW'(s10_eb_q[2])));
      s11_sd_q  <= s10_sd_q;
      s11_bo_q  <= s10_bo_q;
      s11_eye_q <= s10_eye_q;
    end
  end

  // Stage 12: eye dot true up products.
  logic                 s12_vld_q;
  logic signed [EW-1:0] s12_et_q [3];
  logic signed [W-1:0]  s12_tu_q [3];
  logic signed [W-1:0]  s12_sd_q [3];
  logic signed [W-1:0]  s12_bo_q [3];
  logic signed [W-1:0]  s12_ss_q, s12_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s12_et_q[i] <= EW'(s11_eye_q[i]) * EW'(s11_tu_q[i]);
      s12_tu_q <= s11_tu_q;
      s12_sd_q <= s11_sd_q;
      s12_bo_q <= s11_bo_q;
      s12_ss_q <= s11_ss_q;
      s12_sb_q <= s11_sb_q;
    end
  end

  // Stage 13: up translation term and output register.
  logic signed [W-1:0] s13_tu_q [3];
  logic signed [W-1:0] s13_sd_q [3];
  logic signed [W-1:0] s13_bo_q [3];
  logic signed [W-1:0] s13_ss_q, s13_su_q, s13_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s13_su_q <= round_sat(-(SUMW'(s12_et_q[0]) + SUMW'(s12_et_q[1])
                              + SUMW'(s12_et_q[2])));
      s13_tu_q <= s12_tu_q;
      s13_sd_q <= s12_sd_q;
      s13_bo_q <= s12_bo_q;
      s13_ss_q <= s12_ss_q;
      s13_sb_q <= s12_sb_q;
    end
  end

  //--------------------------------------------------------------------------
  // Valid bits of the local stages; advance with the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= src_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= sq_vld;
      s7_vld_q  <= dv_vld;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
    end
  end

  assign dst_o.valid      = s13_vld_q;
  assign dst_o.side_x     = s13_sd_q[0];
  assign dst_o.side_y     = s13_sd_q[1];
  assign dst_o.side_z     = s13_sd_q[2];
  assign dst_o.true_up_x  = s13_tu_q[0];
  assign dst_o.true_up_y  = s13_tu_q[1];
  assign dst_o.true_up_z  = s13_tu_q[2];
  assign dst_o.back_x     = s13_bo_q[0];
  assign dst_o.back_y     = s13_bo_q[1];
  assign dst_o.back_z     = s13_bo_q[2];
  assign dst_o.shift_side = s13_ss_q;
  assign dst_o.shift_up   = s13_su_q;
  assign dst_o.shift_back = s13_sb_q;

  //--------------------------------------------------------------------------
  // Scaling must land the largest magnitude exactly on its top bit.
  a_scale_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && !s3_zero_q |-> s3_sc_or[NormTop])
    else $error("scaled magnitudes miss the top bit");

  // A nonzero direction has a root no smaller than 2 to the power NormTop.
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_vld_q && !s6_side_q[SideB-1] |-> (s6_r_q >> NormTop) != '0)
    else $error("root below normalized range");

  // Normalized components never exceed one.
  a_back_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s7_vld_q |-> (s7_bk_q[0] <= One) && (s7_bk_q[0] >= -One)
              && (s7_bk_q[1] <= One) && (s7_bk_q[1] >= -One)
              && (s7_bk_q[2] <= One) && (s7_bk_q[2] >= -One))
    else $error("back component beyond unit");

endmodule

FILE: tb/lav_tb_if.sv
// Testbench copy note: block interfaces live in src; this file holds the request and result types.
`timescale 1ns / 1ps
package lav_tb_pkg;
  import lav_pkg::*;

  typedef logic signed [WordBitsDef-1:0] word_t;

  typedef struct {
    word_t up_x, up_y, up_z;
    word_t target_x, target_y, target_z;
    word_t eye_x, eye_y, eye_z;
  } camera_req_t;

  typedef struct {
    word_t side_x, side_y, side_z;
    word_t true_up_x, true_up_y, true_up_z;
    word_t back_x, back_y, back_z;
    word_t shift_side, shift_up, shift_back;
  } view_matrix_t;
endpackage

FILE: tb/tb.sv
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 1ps
module tb;
  import lav_pkg::*;
  import lav_tb_pkg::*;

  localparam int FB = FracBitsDef;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int LATENCY = 45 + FB;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lav_req_if #(.WordBits(WordBitsDef)) req_if ();
  lav_rsp_if #(.WordBits(WordBitsDef)) rsp_if ();

  look_at_view_matrix #(.WORD_BITS(WordBitsDef), .FRACTION_BITS(FB)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .src_i (req_if),
    .dst_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  camera_req_t  pending_reqs[$];
  view_matrix_t expected_views[$];
  int           error_count = 0;
  int           checked_count = 0;
  longint       cycle_count = 0;
  int           send_idle_pct = 0;   // chance per cycle that the sender holds off
  int           recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int           hold_off_left = 0;   // long receiver hold-off, counted down below

  // ---------------- prediction ----------------
  function automatic longint floor_div_frac(longint x);
    return x >>> FB;  // arithmetic shift floors
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  // Sum of three exact products, divided by 2^FB rounding half up, saturated.
  // Products may exceed 64 bits, so sum in 128-bit arithmetic.
  function automatic longint round_sum(logic signed [127:0] a, logic signed [127:0] b,
                                       logic signed [127:0] c);
    logic signed [127:0] s;
    s = a + b + c + (128'sd1 <<< (FB - 1));
    s = s >>> FB;
    if (s > WMAX) return WMAX;
    if (s < WMIN) return WMIN;
    return longint'(s);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalize eye minus target into the back vector.
  function automatic void normalize_dir(input longint d[3], output longint o[3]);
    logic [63:0] mag[3];
    logic [63:0] m, len2, r, q;
    int top;
    m = 0;
    len2 = 0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return;
    end
    while ((m >> top) > 1) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > NormTop) mag[i] >>= (top - NormTop);
      else mag[i] <<= (NormTop - top);
      len2 += mag[i] * mag[i];
    end
    r = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FB) + (r >> 1)) / r;
      o[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic view_matrix_t compute_view(camera_req_t c);
    view_matrix_t v;
    longint up[3], eye[3], d[3], bk[3], sd[3], tu[3];
    logic signed [127:0] p[3];
    up  = '{longint'(c.up_x), longint'(c.up_y), longint'(c.up_z)};
    eye = '{longint'(c.eye_x), longint'(c.eye_y), longint'(c.eye_z)};
    d   = '{longint'(c.eye_x) - c.target_x, longint'(c.eye_y) - c.target_y,
            longint'(c.eye_z) - c.target_z};
    normalize_dir(d, bk);
    sd[0] = round_sum(128'(up[1]) * bk[2], -(128'(up[2]) * bk[1]), 0);
    sd[1] = round_sum(128'(up[2]) * bk[0], -(128'(up[0]) * bk[2]), 0);
    sd[2] = round_sum(128'(up[0]) * bk[1], -(128'(up[1]) * bk[0]), 0);
    tu[0] = round_sum(128'(bk[1]) * sd[2], -(128'(bk[2]) * sd[1]), 0);
    tu[1] = round_sum(128'(bk[2]) * sd[0], -(128'(bk[0]) * sd[2]), 0);
    tu[2] = round_sum(128'(bk[0]) * sd[1], -(128'(bk[1]) * sd[0]), 0);
    v.side_x = word_t'(sd[0]); v.side_y = word_t'(sd[1]); v.side_z = word_t'(sd[2]);
    v.true_up_x = word_t'(tu[0]); v.true_up_y = word_t'(tu[1]);
    v.true_up_z = word_t'(tu[2]);
    v.back_x = word_t'(clamp_word(bk[0])); v.back_y = word_t'(clamp_word(bk[1]));
    v.back_z = word_t'(clamp_word(bk[2]));
    for (int i = 0; i < 3; i++) p[i] = -(128'(eye[i]) * sd[i]);
    v.shift_side = word_t'(round_sum(p[0], p[1], p[2]));
    for (int i = 0; i < 3; i++) p[i] = -(128'(eye[i]) * tu[i]);
    v.shift_up = word_t'(round_sum(p[0], p[1], p[2]));
    for (int i = 0; i < 3; i++) p[i] = -(128'(eye[i]) * bk[i]);
    v.shift_back = word_t'(round_sum(p[0], p[1], p[2]));
    return v;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic word_t rand_word(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 20 << FB)) - (10 << FB));
      2: return word_t'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
      default: begin
        case ($urandom_range(0, 3))
          0: return word_t'(WMAX);
          1: return word_t'(WMIN);
          2: return '0;
          default: return word_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic camera_req_t rand_camera();
    camera_req_t c;
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) begin
      // plausible scenes: unit-ish up, moderate coordinates
      c.up_x = rand_word(2); c.up_y = rand_word(2); c.up_z = rand_word(2);
      c.target_x = rand_word(1); c.target_y = rand_word(1); c.target_z = rand_word(1);
      c.eye_x = rand_word(1); c.eye_y = rand_word(1); c.eye_z = rand_word(1);
      if ($urandom_range(0, 19) == 0) begin
        c.eye_x = c.target_x; c.eye_y = c.target_y; c.eye_z = c.target_z;
      end
    end else begin
      m = (m == 9) ? 3 : 0;
      c.up_x = rand_word(m); c.up_y = rand_word(m); c.up_z = rand_word(m);
      c.target_x = rand_word(m); c.target_y = rand_word(m); c.target_z = rand_word(m);
      c.eye_x = rand_word(m); c.eye_y = rand_word(m); c.eye_z = rand_word(m);
    end
    return c;
  endfunction

  function automatic camera_req_t make_camera(longint u0, longint u1, longint u2,
      longint t0, longint t1, longint t2, longint e0, longint e1, longint e2);
    camera_req_t c;
    c.up_x = word_t'(u0); c.up_y = word_t'(u1); c.up_z = word_t'(u2);
    c.target_x = word_t'(t0); c.target_y = word_t'(t1); c.target_z = word_t'(t2);
    c.eye_x = word_t'(e0); c.eye_y = word_t'(e1); c.eye_z = word_t'(e2);
    return c;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    error_count++;
    $display("mismatch at view %0d field %s: got %0d expected %0d",
             checked_count, field, got, want);
  endtask

  // ---------------- driver ----------------
  // Hold the request while valid and not ready; advance on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          camera_req_t c;
          c = pending_reqs.pop_front();
          expected_views.push_back(compute_view(c));
          req_if.valid    <= 1'b1;
          req_if.up_x     <= c.up_x;     req_if.up_y     <= c.up_y;
          req_if.up_z     <= c.up_z;
          req_if.target_x <= c.target_x; req_if.target_y <= c.target_y;
          req_if.target_z <= c.target_z;
          req_if.eye_x    <= c.eye_x;    req_if.eye_y    <= c.eye_y;
          req_if.eye_z    <= c.eye_z;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver and checker ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected view", 0, 0);
        end else begin
          view_matrix_t w;
          w = expected_views.pop_front();
          if (rsp_if.side_x !== w.side_x) report_mismatch("side_x", rsp_if.side_x, w.side_x);
          if (rsp_if.side_y !== w.side_y) report_mismatch("side_y", rsp_if.side_y, w.side_y);
          if (rsp_if.side_z !== w.side_z) report_mismatch("side_z", rsp_if.side_z, w.side_z);
          if (rsp_if.true_up_x !== w.true_up_x)
            report_mismatch("true_up_x", rsp_if.true_up_x, w.true_up_x);
          if (rsp_if.true_up_y !== w.true_up_y)
            report_mismatch("true_up_y", rsp_if.true_up_y, w.true_up_y);
          if (rsp_if.true_up_z !== w.true_up_z)
            report_mismatch("true_up_z", rsp_if.true_up_z, w.true_up_z);
          if (rsp_if.back_x !== w.back_x) report_mismatch("back_x", rsp_if.back_x, w.back_x);
          if (rsp_if.back_y !== w.back_y) report_mismatch("back_y", rsp_if.back_y, w.back_y);
          if (rsp_if.back_z !== w.back_z) report_mismatch("back_z", rsp_if.back_z, w.back_z);
          if (rsp_if.shift_side !== w.shift_side)
            report_mismatch("shift_side", rsp_if.shift_side, w.shift_side);
          if (rsp_if.shift_up !== w.shift_up)
            report_mismatch("shift_up", rsp_if.shift_up, w.shift_up);
          if (rsp_if.shift_back !== w.shift_back)
            report_mismatch("shift_back", rsp_if.shift_back, w.shift_back);
          checked_count++;
        end
      end
      // A long hold-off wins over the random stall.
      if (hold_off_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------- hold-off counter ----------------
  always @(posedge clk_i) begin
    if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_views.size() > 0) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_camera());
  endtask

  initial begin
    longint one;
    one = 64'sd1 << FB;
    // Drive every input known before reset lifts.
    req_if.valid = 1'b0;
    req_if.up_x = '0; req_if.up_y = '0; req_if.up_z = '0;
    req_if.target_x = '0; req_if.target_y = '0; req_if.target_z = '0;
    req_if.eye_x = '0; req_if.eye_y = '0; req_if.eye_z = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: canonical view, eye at target, extremes and all-ones patterns.
    pending_reqs.push_back(make_camera(0, one, 0, 0, 0, 0, 0, 0, 5 * one));
    pending_reqs.push_back(make_camera(0, one, 0, one, 2 * one, 3 * one,
                                       one, 2 * one, 3 * one));
    pending_reqs.push_back(make_camera(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_camera(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN,
                                       WMAX, WMAX, WMAX));
    pending_reqs.push_back(make_camera(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX,
                                       WMIN, WMIN, WMIN));
    pending_reqs.push_back(make_camera(WMIN, WMAX, WMIN, WMAX, 0, WMIN,
                                       WMIN, WMAX, WMAX));
    pending_reqs.push_back(make_camera(-1, -1, -1, 0, 0, 0, -1, -1, -1));
    pending_reqs.push_back(make_camera(one, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_reqs.push_back(make_camera(3 * one, -2 * one, 7 * one, 0, 0, 0,
                                       WMAX, 1, -1));
    pending_reqs.push_back(make_camera(0, one, 0, 0, 0, 0, 0, WMAX, 0));
    pending_reqs.push_back(make_camera(0, WMAX, 0, 0, 0, 0, WMIN, 0, WMAX));
    wait_drained();

    // Back to back with no idling.
    queue_random(300);
    wait_drained();

    send_idle_pct = 77;
    queue_random(250);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 77;
    queue_random(250);
    wait_drained();

    send_idle_pct = 7;
    recv_stall_pct = 7;
    queue_random(250);
    // Hold off the receiver long enough for the pipe to fill and stall its input.
    hold_off_left = 3 * LATENCY;
    wait_drained();

    recv_stall_pct = 0;
    send_idle_pct = 0;
    queue_random(150);
    wait_drained();

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("checked %0d view matrices over idle, stall and back-to-back phases",
             checked_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
